[src/lkvc_pkg.sv]
// ---------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key/value cache.
// ---------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 64;
    localparam int NS_W        = 8;
    localparam int ID_W        = 56;
    localparam int HANDLE_BITS = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 32;

    localparam logic [DATA_W-1:0] HANDLE_MASK = DATA_W'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        REQ_GET   = 2'd0,
        REQ_PUT   = 2'd1,
        REQ_INVAL = 2'd2,
        REQ_STATS = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_FIN
    } state_t;

    // Counter bank control
    typedef struct packed {
        logic hit_inc;
        logic miss_inc;
        logic evict_inc;
        logic clear;
    } stat_ctl_t;

endpackage

[src/lkvc_stats.sv]
// ---------------------------------------------------------------------------
// lkvc_stats
// Saturating hit, miss and eviction counters with a clear.
// ---------------------------------------------------------------------------
module lkvc_stats
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stat_ctl_t        ctl,
    output logic [CNT_W-1:0] hit_count,
    output logic [CNT_W-1:0] miss_count,
    output logic [CNT_W-1:0] eviction_count
);

    logic [CNT_W-1:0] hit_reg,  hit_next;
    logic [CNT_W-1:0] miss_reg, miss_next;
    logic [CNT_W-1:0] ev_reg,   ev_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

    always_comb
    begin
        hit_next  = hit_reg;
        miss_next = miss_reg;
        ev_next   = ev_reg;
        if (ctl.clear)
        begin
            hit_next  = '0;
            miss_next = '0;
            ev_next   = '0;
        end
        else
        begin
            if (ctl.hit_inc)   hit_next  = sat_inc(hit_reg);
            if (ctl.miss_inc)  miss_next = sat_inc(miss_reg);
            if (ctl.evict_inc) ev_next   = sat_inc(ev_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= '0;
            miss_reg <= '0;
            ev_reg   <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            miss_reg <= miss_next;
            ev_reg   <= ev_next;
        end
    end

    assign hit_count      = hit_reg;
    assign miss_count     = miss_reg;
    assign eviction_count = ev_reg;

endmodule

[src/lru_key_value_cache.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative LRU cache, 64 entries, key = {name_space, key_id}.
// ---------------------------------------------------------------------------
// One request at a time. Get and put walk the entry memory once, one entry a
// cycle, to find the key, the first free slot and the least recently used
// slot; after the registered read of the last entry the walk ends with a
// decision step. A get hit, a put hit and an eviction then walk the rank
// memory a second time to age the ranks; a get miss or a put into a free
// slot finishes without it, and an invalidate or a stats request does no
// walk at all. Both walks are set by the single read port of each memory. A
// finished result sits in the output register; the next request may be
// taken while it waits there, but cannot finish until the register has been
// emptied.
// ---------------------------------------------------------------------------
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // name_space[7:0], key_id[63:8], payload_handle[95:64], payload_total[127:96]
    input  logic [127:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], out_handle[32:1], out_total[64:33], evicted[65], hit_count[97:66],
    // miss_count[129:98], eviction_count[161:130], zero pad [167:162]
    output logic [167:0] m_axis_tdata
);

    // entry memory: {key, handle, total}; rank memory: 0 = least recent
    logic [KEY_W+2*DATA_W-1:0] ent_mem [CAPACITY];
    logic [IDX_W-1:0]          rank_mem [CAPACITY];

    logic [KEY_W+2*DATA_W-1:0] ent_q_reg;
    logic [IDX_W-1:0]          rank_q_reg;

    logic                      ent_we;
    logic [IDX_W-1:0]          ent_waddr;
    logic [KEY_W+2*DATA_W-1:0] ent_wdata;
    logic                      rank_we;
    logic [IDX_W-1:0]          rank_waddr;
    logic [IDX_W-1:0]          rank_wdata;
    logic [IDX_W-1:0]          raddr;

    state_t state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OCC_W-1:0]    cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;

    req_t                req_reg, req_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]   hdl_reg, hdl_next;
    logic [DATA_W-1:0]   tot_reg, tot_next;

    // walk results
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    fslot_reg, fslot_next;
    logic [IDX_W-1:0]    frank_reg, frank_next;
    logic [DATA_W-1:0]   fhdl_reg, fhdl_next;
    logic [DATA_W-1:0]   ftot_reg, ftot_next;
    logic                free_reg, free_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic                lru_reg, lru_next;
    logic [IDX_W-1:0]    lru_slot_reg, lru_slot_next;
    logic                evict_reg, evict_next;

    // slot to promote and its old rank
    logic [IDX_W-1:0]    pslot_reg, pslot_next;
    logic [IDX_W-1:0]    prank_reg, prank_next;

    logic                out_vld_reg, out_vld_next;
    logic [167:0]        out_reg, out_next;

    stat_ctl_t           sctl;
    logic [CNT_W-1:0]    hit_cnt, miss_cnt, ev_cnt;
    logic [OCC_W-1:0]    occ_m1;
    logic [KEY_W-1:0]    q_key;
    logic                accept;

    lkvc_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (sctl),
        .hit_count      (hit_cnt),
        .miss_count     (miss_cnt),
        .eviction_count (ev_cnt)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;
    assign q_key         = ent_q_reg[KEY_W+2*DATA_W-1:2*DATA_W];
    assign occ_m1        = occ_reg - OCC_W'(1);
    assign raddr         = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = raddr;
        req_next       = req_reg;
        key_next       = key_reg;
        hdl_next       = hdl_reg;
        tot_next       = tot_reg;
        found_next     = found_reg;
        fslot_next     = fslot_reg;
        frank_next     = frank_reg;
        fhdl_next      = fhdl_reg;
        ftot_next      = ftot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        lru_next       = lru_reg;
        lru_slot_next  = lru_slot_reg;
        evict_next     = evict_reg;
        pslot_next     = pslot_reg;
        prank_next     = prank_reg;
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;
        ent_we         = 1'b0;
        ent_waddr      = fslot_reg;
        ent_wdata      = {key_reg, hdl_reg, tot_reg};
        rank_we        = 1'b0;
        rank_waddr     = chk_idx_reg;
        rank_wdata     = rank_q_reg;
        sctl           = '0;

        if (out_vld_reg && m_axis_tready)
            out_vld_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_t'(s_axis_tuser);
                    key_next   = {s_axis_tdata[7:0], s_axis_tdata[63:8]};
                    hdl_next   = s_axis_tdata[95:64] & HANDLE_MASK;
                    tot_next   = s_axis_tdata[127:96];
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    lru_next   = 1'b0;
                    evict_next = 1'b0;
                    fhdl_next  = '0;
                    ftot_next  = '0;
                    cnt_next   = '0;
                    unique case (req_t'(s_axis_tuser))
                        REQ_GET, REQ_PUT: state_next = ST_SEARCH;
                        REQ_INVAL:
                        begin
                            valid_next = '0;
                            occ_next   = '0;
                            state_next = ST_FIN;
                        end
                        REQ_STATS: state_next = ST_FIN;
                        default: state_next = ST_FIN;
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if (cnt_reg < OCC_W'(CAPACITY))
                begin
                    chk_vld_next = 1'b1;
                    cnt_next     = cnt_reg + OCC_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg] && q_key == key_reg && !found_reg)
                    begin
                        found_next = 1'b1;
                        fslot_next = chk_idx_reg;
                        frank_next = rank_q_reg;
                        fhdl_next  = ent_q_reg[2*DATA_W-1:DATA_W];
                        ftot_next  = ent_q_reg[DATA_W-1:0];
                    end
                    if (!valid_reg[chk_idx_reg] && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = chk_idx_reg;
                    end
                    if (valid_reg[chk_idx_reg] && rank_q_reg == '0 && !lru_reg)
                    begin
                        lru_next      = 1'b1;
                        lru_slot_next = chk_idx_reg;
                    end
                end
                else if (cnt_reg == OCC_W'(CAPACITY))
                begin
                    // walk done: decide
                    cnt_next   = '0;
                    pslot_next = fslot_reg;
                    prank_next = frank_reg;
                    if (req_reg == REQ_GET)
                    begin
                        sctl.hit_inc  = found_reg;
                        sctl.miss_inc = !found_reg;
                        state_next    = found_reg ? ST_UPDATE : ST_FIN;
                    end
                    else if (found_reg)
                    begin
                        ent_we     = 1'b1;
                        ent_waddr  = fslot_reg;
                        state_next = ST_UPDATE;
                    end
                    else if (occ_reg >= OCC_W'(CAPACITY))
                    begin
                        // no rank-0 entry cannot happen when full; slot 0 fallback
                        ent_we         = 1'b1;
                        ent_waddr      = lru_reg ? lru_slot_reg : '0;
                        pslot_next     = ent_waddr;
                        prank_next     = '0;
                        evict_next     = 1'b1;
                        sctl.evict_inc = 1'b1;
                        state_next     = ST_UPDATE;
                    end
                    else
                    begin
                        ent_we      = 1'b1;
                        ent_waddr   = free_reg ? free_slot_reg : '0;
                        rank_we     = 1'b1;
                        rank_waddr  = ent_waddr;
                        rank_wdata  = occ_reg[IDX_W-1:0];
                        valid_next[ent_waddr] = 1'b1;
                        occ_next    = occ_reg + OCC_W'(1);
                        state_next  = ST_FIN;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (cnt_reg < OCC_W'(CAPACITY))
                begin
                    chk_vld_next = 1'b1;
                    cnt_next     = cnt_reg + OCC_W'(1);
                end
                if (chk_vld_reg)
                begin
                    rank_waddr = chk_idx_reg;
                    if (chk_idx_reg == pslot_reg)
                    begin
                        rank_we    = 1'b1;
                        rank_wdata = occ_m1[IDX_W-1:0];
                    end
                    else if (valid_reg[chk_idx_reg] && rank_q_reg > prank_reg)
                    begin
                        rank_we    = 1'b1;
                        rank_wdata = rank_q_reg - IDX_W'(1);
                    end
                end
                else if (cnt_reg == OCC_W'(CAPACITY))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next = 1'b1;
                    out_next     = '0;
                    if (req_reg == REQ_GET && found_reg)
                    begin
                        out_next[0]    = 1'b1;
                        out_next[32:1] = fhdl_reg;
                        out_next[64:33] = ftot_reg;
                    end
                    if (req_reg == REQ_PUT)
                        out_next[65] = evict_reg;
                    if (req_reg == REQ_STATS)
                    begin
                        out_next[97:66]   = hit_cnt;
                        out_next[129:98]  = miss_cnt;
                        out_next[161:130] = ev_cnt;
                        sctl.clear        = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            occ_reg     <= '0;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        req_reg       <= req_next;
        key_reg       <= key_next;
        hdl_reg       <= hdl_next;
        tot_reg       <= tot_next;
        found_reg     <= found_next;
        fslot_reg     <= fslot_next;
        frank_reg     <= frank_next;
        fhdl_reg      <= fhdl_next;
        ftot_reg      <= ftot_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        lru_reg       <= lru_next;
        lru_slot_reg  <= lru_slot_next;
        evict_reg     <= evict_next;
        pslot_reg     <= pslot_next;
        prank_reg     <= prank_next;
        out_reg       <= out_next;
    end

    // memories: one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_q_reg <= ent_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        rank_q_reg <= rank_mem[raddr];
    end

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == occ_reg)
        else $error("occupancy disagrees with valid bits");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && evict_reg) |-> occ_reg == OCC_W'(CAPACITY))
        else $error("eviction while not full");

    a_fin_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && state_next == ST_FIN) |-> !chk_vld_reg)
        else $error("rank walk left early");
`endif

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache: directed table then random
// get/put/invalidate/stats traffic, every result checked against a predictor.
// ---------------------------------------------------------------------------
module tb
    import lkvc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // name_space[7:0], key_id[63:8], payload_handle[95:64], payload_total[127:96]
    logic [127:0] s_axis_tdata = '0;
    // req_type[1:0]
    logic [1:0]   s_axis_tuser = REQ_GET;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // hit[0], out_handle[32:1], out_total[64:33], evicted[65], hit_count[97:66],
    // miss_count[129:98], eviction_count[161:130], zero pad [167:162]
    logic [167:0] m_axis_tdata;

    lru_key_value_cache DUT (.*);

    always #1 clk = ~clk;

    typedef struct packed {
        req_t        req;
        logic [7:0]  ns;
        logic [55:0] id;
        logic [31:0] handle;
        logic [31:0] total;
    } cache_req_t;

    // Shadow copy of the cache
    logic        line_valid [CAPACITY];
    logic [63:0] line_key   [CAPACITY];
    logic [31:0] line_handle[CAPACITY];
    logic [31:0] line_total [CAPACITY];
    int          line_rank  [CAPACITY];
    int          fill;
    logic [31:0] n_hits, n_misses, n_evicts;

    logic [167:0] pending_results[$];
    int  errors = 0;
    int  n_sent = 0, n_recv = 0, n_evicted = 0, n_hit = 0;
    int  send_idle = 15, recv_idle = 84;
    longint cycles = 0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void promote(int s);
        int r;
        r = line_rank[s];
        for (int i = 0; i < CAPACITY; i++)
            if (line_valid[i] && i != s && line_rank[i] > r)
                line_rank[i]--;
        line_rank[s] = (fill > 0) ? fill - 1 : 0;
    endfunction

    // Apply one request to the shadow and return the response word
    function automatic logic [167:0] cache_response(cache_req_t q);
        logic [63:0]  k;
        logic [167:0] r;
        int s;
        k = {q.ns, q.id};
        r = '0;
        s = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (s < 0 && line_valid[i] && line_key[i] == k)
                s = i;
        case (q.req)
            REQ_GET:
            begin
                if (s >= 0)
                begin
                    promote(s);
                    r[0] = 1'b1;
                    r[32:1] = line_handle[s];
                    r[64:33] = line_total[s];
                    n_hits = bump(n_hits);
                end
                else
                    n_misses = bump(n_misses);
            end
            REQ_PUT:
            begin
                if (s >= 0)
                begin
                    line_handle[s] = q.handle & HANDLE_MASK;
                    line_total[s] = q.total;
                    promote(s);
                end
                else if (fill >= CAPACITY)
                begin
                    s = 0;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (line_valid[i] && line_rank[i] == 0)
                            s = i;
                    line_key[s] = k;
                    line_handle[s] = q.handle & HANDLE_MASK;
                    line_total[s] = q.total;
                    line_rank[s] = 0;
                    promote(s);
                    n_evicts = bump(n_evicts);
                    r[65] = 1'b1;
                end
                else
                begin
                    s = 0;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!line_valid[i])
                            s = i;
                    line_valid[s] = 1'b1;
                    line_key[s] = k;
                    line_handle[s] = q.handle & HANDLE_MASK;
                    line_total[s] = q.total;
                    line_rank[s] = fill;
                    fill++;
                end
            end
            REQ_INVAL:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    line_valid[i] = 1'b0;
                fill = 0;
            end
            default:
            begin
                r[97:66] = n_hits;
                r[129:98] = n_misses;
                r[161:130] = n_evicts;
                n_hits = '0;
                n_misses = '0;
                n_evicts = '0;
            end
        endcase
        return r;
    endfunction

    // Send one transfer; hold-off before it per the sender idle rate
    task automatic send(cache_req_t q);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= q.req;
        s_axis_tdata  <= {q.total, q.handle, q.id, q.ns};
        pending_results.push_back(cache_response(q));
        n_sent++;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Receiver: random stalls, compare on each transfer
    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                errors++;
            end
            else
            begin
                logic [167:0] e;
                e = pending_results.pop_front();
                n_recv++;
                if (e[0]) n_hit++;
                if (e[65]) n_evicted++;
                if (e !== m_axis_tdata)
                begin
                    errors++;
                    $display("%0t: mismatch hit exp %0b got %0b, handle exp %h got %h",
                             $realtime, e[0], m_axis_tdata[0], e[32:1], m_axis_tdata[32:1]);
                    $display("%0t:   total exp %h got %h, evicted exp %0b got %0b",
                             $realtime, e[64:33], m_axis_tdata[64:33], e[65],
                             m_axis_tdata[65]);
                    $display("%0t:   counts exp %h got %h", $realtime, e[161:66],
                             m_axis_tdata[161:66]);
                end
            end
        end
        if (cycles > 64'd4_000_000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic cache_req_t mk(req_t t, logic [7:0] ns, logic [55:0] id,
                                      logic [31:0] h, logic [31:0] tot);
        cache_req_t q;
        q.req = t; q.ns = ns; q.id = id; q.handle = h; q.total = tot;
        return q;
    endfunction

    // Random request; keys drawn from a small pool so hits and evictions occur
    function automatic cache_req_t rand_req(int pool);
        cache_req_t q;
        int p;
        p = $urandom_range(99);
        q.req = (p < 45) ? REQ_GET : (p < 93) ? REQ_PUT : (p < 95) ? REQ_INVAL : REQ_STATS;
        if ($urandom_range(9) == 0)
        begin
            q.ns = 8'($urandom);
            q.id = {24'($urandom), 32'($urandom)};
        end
        else
        begin
            q.ns = 8'($urandom_range(pool) % 3);
            q.id = 56'($urandom_range(pool));
        end
        q.handle = $urandom;
        q.total = $urandom;
        return q;
    endfunction

    // Directed table: each row's expected response is typed in and checked against the predictor
    cache_req_t directed_q[] = '{
        mk(REQ_STATS, 8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_GET,   8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_PUT,   8'hFF, 56'hFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
        mk(REQ_GET,   8'hFF, 56'hFF_FFFF_FFFF_FFFF, 32'h0, 32'h0),
        mk(REQ_PUT,   8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_GET,   8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_PUT,   8'hFF, 56'hFF_FFFF_FFFF_FFFF, 32'h1234_5678, 32'h8765_4321),
        mk(REQ_GET,   8'hFF, 56'hFF_FFFF_FFFF_FFFF, 32'h0, 32'h0),
        mk(REQ_GET,   8'hFE, 56'hFF_FFFF_FFFF_FFFF, 32'h0, 32'h0),
        mk(REQ_STATS, 8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_INVAL, 8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_GET,   8'h00, 56'h0, 32'h0, 32'h0),
        mk(REQ_STATS, 8'h00, 56'h0, 32'h0, 32'h0)
    };
    // Typed-in responses, one per table row; each must match the predictor exactly
    logic [167:0] directed_r[] = '{
        168'h0,
        168'h0,
        168'h0,
        {103'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
        168'h0,
        {135'h0, 32'h0, 1'b1},
        168'h0,
        {103'h0, 32'h8765_4321, 32'h1234_5678, 1'b1},
        168'h0,
        {6'h0, 32'h0, 32'h2, 32'h3, 66'h0},
        168'h0,
        168'h0,
        {6'h0, 32'h0, 32'h1, 32'h0, 66'h0}
    };

    initial
    begin
        logic [167:0] p;
        int pool;
        for (int i = 0; i < CAPACITY; i++)
        begin
            line_valid[i] = 1'b0;
            line_rank[i] = 0;
        end
        fill = 0;
        n_hits = '0; n_misses = '0; n_evicts = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_q[i])
        begin
            send(directed_q[i]);
            p = pending_results[$];
            if (p !== directed_r[i])
            begin
                errors++;
                $display("%0t: table row %0d expected %h, predictor %h",
                         $realtime, i, directed_r[i], p);
            end
        end

        // Fill past capacity in order, then touch the second-oldest key to steer eviction
        for (int i = 0; i < CAPACITY + 8; i++)
            send(mk(REQ_PUT, 8'h5A, 56'(i), $urandom, $urandom));
        send(mk(REQ_GET, 8'h5A, 56'd9, 32'h0, 32'h0));
        for (int i = 0; i < 4; i++)
            send(mk(REQ_PUT, 8'h5B, 56'(i), $urandom, $urandom));
        send(mk(REQ_STATS, 8'h0, 56'h0, 32'h0, 32'h0));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 15 : (phase == 1) ? 84 : 0;
            recv_idle = (phase == 0) ? 84 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < 400; n++)
            begin
                pool = (n % 100 < 50) ? 90 : 40;
                send(rand_req(pool));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d requests, checked %0d results", n_sent, n_recv);
        $display("Of those %0d get hits and %0d evictions", n_hit, n_evicted);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
